// ===== rtl/uate_pkg.sv =====
// ----------------------------------------------------------------------------
// uate_pkg
// shared types and codes for the unsorted array table engine
// ----------------------------------------------------------------------------
package uate_pkg;

    // most results one dump request may produce
    localparam int MAX_RESULTS = 16;

    // operation codes
    localparam logic [2:0] FN_INSERT = 3'd0;
    localparam logic [2:0] FN_DUMP   = 3'd1;
    localparam logic [2:0] FN_SEARCH = 3'd2;
    localparam logic [2:0] FN_UPDATE = 3'd3;
    localparam logic [2:0] FN_DELETE = 3'd4;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] key;
        logic signed [31:0] new_value;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [3:0]         position;
        logic signed [31:0] entry_value;
        logic [4:0]         fill_count;
        logic               last;
    } res_t;

endpackage

// ===== rtl/unsorted_array_table_engine.sv =====
// ----------------------------------------------------------------------------
// unsorted_array_table_engine
// insertion-ordered table of signed 32-bit values with linear search
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------
//   cmd      | in        | cmd_valid/cmd_ready  | func, key, new_value
//   res      | out       | res_valid/res_ready  | status, position,
//            |           |                      | entry_value, fill_count, last
//
// one request is worked at a time; the single read port of the entry memory
// sets the pace at one slot per cycle, while a dump also waits on res_ready:
//   insert and unused codes go straight to the reply; search and update scan
//   up to the first match or the fill count; delete scans as search, then
//   moves every later entry one slot lower to close the gap;
//   dump reads one entry per result, up to MAX_RESULTS results.
// reset clears the fill count and the sequencer state, not the entries; entry contents are undefined until written.
// a stalled res channel holds the sequencer once the output register is full.
// ----------------------------------------------------------------------------
module unsorted_array_table_engine #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  uate_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output uate_pkg::res_t res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // sequencer to output register
    logic           ctl_res_valid;
    logic           ctl_res_ready;
    uate_pkg::res_t ctl_res;

    // memory port
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [31:0]    mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    logic [31:0]    mem_rdata;

    // output register
    logic           res_valid_reg, res_valid_next;
    uate_pkg::res_t res_data_reg, res_data_next;

    uate_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (ctl_res_valid),
        .res_ready (ctl_res_ready),
        .res       (ctl_res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    uate_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // register slot can take a new result when empty or being drained
    assign ctl_res_ready = !res_valid_reg || res_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (ctl_res_ready)
        begin
            res_valid_next = ctl_res_valid;
            if (ctl_res_valid)
            begin
                res_data_next = ctl_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            res_data_reg  <= res_data_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_data_reg;

endmodule

// ===== rtl/uate_mem.sv =====
// ----------------------------------------------------------------------------
// uate_mem
// entry storage: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module uate_mem #(
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [31:0]                             wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [31:0]                             rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/uate_ctrl.sv =====
// ----------------------------------------------------------------------------
// uate_ctrl
// sequencer: walks the entry memory one slot a cycle (a dump only while res_ready is high) for scan, shift and dump
// ----------------------------------------------------------------------------
module uate_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  uate_pkg::cmd_t        cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output uate_pkg::res_t        res,
    output logic                  mem_we,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_waddr,
    output logic [31:0]           mem_wdata,
    output logic                  mem_re,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_raddr,
    input  logic [31:0]           mem_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DUMP,
        S_RESP
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   match_reg, match_next;
    logic [AW-1:0]   dst_reg, dst_next;
    logic            pend_reg, pend_next;
    uate_pkg::cmd_t  cmd_reg, cmd_next;
    uate_pkg::res_t  res_reg, res_next;

    logic            hit;
    logic [CW-1:0]   idx_inc;
    logic            dump_last;
    uate_pkg::res_t  dump_res;

    // the shared compare unit
    assign hit       = pend_reg && (mem_rdata == $unsigned(cmd_reg.key));
    assign idx_inc   = idx_reg + 1'b1;
    assign dump_last = (idx_inc == count_reg) || (32'(idx_inc) == uate_pkg::MAX_RESULTS);

    assign dump_res = '{status: uate_pkg::ST_OK, position: 4'(idx_reg),
                        entry_value: mem_rdata, fill_count: 5'(count_reg),
                        last: dump_last};

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP) || (state_reg == S_DUMP);
    assign res       = (state_reg == S_DUMP) ? dump_res : res_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        match_next = match_reg;
        dst_next   = dst_reg;
        pend_next  = 1'b0;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    idx_next = '0;
                    case (cmd.func)
                        uate_pkg::FN_INSERT:
                        begin
                            state_next = S_RESP;
                            if (count_reg >= CW'(DEPTH))
                            begin
                                res_next = '{status: uate_pkg::ST_FULL, position: 4'd0,
                                             entry_value: 32'sd0,
                                             fill_count: 5'(count_reg), last: 1'b1};
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = cmd.key;
                                count_next = count_reg + 1'b1;
                                res_next   = '{status: uate_pkg::ST_OK, position: 4'd0,
                                               entry_value: 32'sd0,
                                               fill_count: 5'(count_reg + 1'b1),
                                               last: 1'b1};
                            end
                        end
                        uate_pkg::FN_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = S_RESP;
                                res_next   = '{status: uate_pkg::ST_EMPTY, position: 4'd0,
                                               entry_value: 32'sd0,
                                               fill_count: 5'(count_reg), last: 1'b1};
                            end
                            else
                            begin
                                state_next = S_DUMP;
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                            end
                        end
                        uate_pkg::FN_SEARCH, uate_pkg::FN_UPDATE, uate_pkg::FN_DELETE:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                            res_next   = '{status: uate_pkg::ST_OK, position: 4'd0,
                                           entry_value: 32'sd0,
                                           fill_count: 5'(count_reg), last: 1'b1};
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    res_next = '{status: uate_pkg::ST_OK, position: 4'(match_reg),
                                 entry_value: 32'sd0,
                                 fill_count: 5'(count_reg), last: 1'b1};
                    case (cmd_reg.func)
                        uate_pkg::FN_UPDATE:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = match_reg[AW-1:0];
                            mem_wdata  = cmd_reg.new_value;
                            state_next = S_RESP;
                        end
                        uate_pkg::FN_DELETE:
                        begin
                            idx_next   = match_reg + 1'b1;
                            state_next = S_SHIFT;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
                else if (idx_reg < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg[AW-1:0];
                    pend_next  = 1'b1;
                    match_next = idx_reg;
                    idx_next   = idx_inc;
                end
                else
                begin
                    state_next = S_RESP;
                    res_next   = '{status: uate_pkg::ST_NOT_FOUND, position: 4'd0,
                                   entry_value: 32'sd0,
                                   fill_count: 5'(count_reg), last: 1'b1};
                end
            end

            S_SHIFT:
            begin
                // write back the entry read last cycle one slot lower
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = mem_rdata;
                end
                if (idx_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg[AW-1:0];
                    pend_next = 1'b1;
                    dst_next  = AW'(idx_reg - 1'b1);
                    idx_next  = idx_inc;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_RESP;
                    res_next   = '{status: uate_pkg::ST_OK, position: 4'(match_reg),
                                   entry_value: 32'sd0,
                                   fill_count: 5'(count_reg - 1'b1), last: 1'b1};
                end
            end

            S_DUMP:
            begin
                if (res_ready)
                begin
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_inc[AW-1:0];
                        idx_next  = idx_inc;
                    end
                end
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            match_reg <= '0;
            dst_reg   <= '0;
            pend_reg  <= 1'b0;
            cmd_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            match_reg <= match_next;
            dst_reg   <= dst_next;
            pend_reg  <= pend_next;
            cmd_reg   <= cmd_next;
            res_reg   <= res_next;
        end
    end

endmodule

// ===== rtl/uate_checker.sv =====
// ----------------------------------------------------------------------------
// uate_checker
// port-level checks for the unsorted array table engine
// ----------------------------------------------------------------------------
module uate_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input uate_pkg::cmd_t cmd,
    input logic           res_valid,
    input logic           res_ready,
    input uate_pkg::res_t res
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // the block is busy in the cycle after it takes a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("request taken back to back");

    // empty status only on a lone result from an empty table
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status == uate_pkg::ST_EMPTY) |->
            res.last && (res.fill_count == 5'd0) && (res.entry_value == 32'sd0))
        else $error("bad empty result");

    // error results close the request
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ((res.status == uate_pkg::ST_FULL) ||
                      (res.status == uate_pkg::ST_NOT_FOUND)) |->
            res.last && (res.position == 4'd0))
        else $error("error result not final");

    // only dump results carry a value, and they are ok
    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.entry_value != 32'sd0) |-> (res.status == uate_pkg::ST_OK))
        else $error("value on non-ok result");

endmodule

bind unsorted_array_table_engine uate_checker u_uate_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

// ===== tb/table_checker.sv =====
// ----------------------------------------------------------------------------
// table_checker
// watches both channels of the table engine, keeps its own copy of the
// table, works out the replies to each request and compares them in order
// ----------------------------------------------------------------------------
module table_checker #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  logic           cmd_ready,
    input  uate_pkg::cmd_t cmd,
    input  logic           res_valid,
    input  logic           res_ready,
    input  uate_pkg::res_t res,
    output int             fails,
    output int             pending,
    output int             checked
);

    logic [31:0]    stored [DEPTH];
    logic [4:0]     fill;
    uate_pkg::res_t awaited_replies [$];

    initial
    begin
        fails   = 0;
        pending = 0;
        checked = 0;
        fill    = '0;
    end

    task automatic report_mismatch(input string msg);
        fails++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // apply one request to the local table and queue the replies it causes
    task automatic table_op_outcome(input uate_pkg::cmd_t c);
        uate_pkg::res_t r;
        int   hit;
        int   n;
        int   j;
        r      = '0;
        r.last = 1'b1;
        hit    = -1;
        case (c.func)
            uate_pkg::FN_INSERT:
            begin
                if (fill >= DEPTH)
                    r.status = uate_pkg::ST_FULL;
                else
                begin
                    stored[fill] = c.key;
                    fill = fill + 1'b1;
                end
                r.fill_count = fill;
                awaited_replies.push_back(r);
            end
            uate_pkg::FN_DUMP:
            begin
                r.fill_count = fill;
                if (fill == 0)
                begin
                    r.status = uate_pkg::ST_EMPTY;
                    awaited_replies.push_back(r);
                end
                else
                begin
                    n = (fill < uate_pkg::MAX_RESULTS) ? fill : uate_pkg::MAX_RESULTS;
                    for (j = 0; j < n; j++)
                    begin
                        r.position    = 4'(j);
                        r.entry_value = stored[j];
                        r.last        = (j == n - 1);
                        awaited_replies.push_back(r);
                    end
                end
            end
            uate_pkg::FN_SEARCH, uate_pkg::FN_UPDATE, uate_pkg::FN_DELETE:
            begin
                for (j = 0; j < fill; j++)
                    if (hit < 0 && stored[j] == c.key)
                        hit = j;
                if (hit < 0)
                    r.status = uate_pkg::ST_NOT_FOUND;
                else
                begin
                    r.position = 4'(hit);
                    if (c.func == uate_pkg::FN_UPDATE)
                        stored[hit] = c.new_value;
                    else if (c.func == uate_pkg::FN_DELETE)
                    begin
                        for (j = hit; j + 1 < fill; j++)
                            stored[j] = stored[j + 1];
                        fill = fill - 1'b1;
                    end
                end
                r.fill_count = fill;
                awaited_replies.push_back(r);
            end
            default:
            begin
                r.fill_count = fill;
                awaited_replies.push_back(r);
            end
        endcase
    endtask

    task automatic compare_reply(input uate_pkg::res_t got);
        uate_pkg::res_t want;
        if (awaited_replies.size() == 0)
        begin
            report_mismatch($sformatf("reply with no request outstanding (status %0d pos %0d)",
                                      got.status, got.position));
            return;
        end
        want = awaited_replies.pop_front();
        checked++;
        if (got.status !== want.status)
            report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                      checked, got.status, want.status));
        if (got.position !== want.position)
            report_mismatch($sformatf("reply %0d position %0d, expected %0d",
                                      checked, got.position, want.position));
        if (got.entry_value !== want.entry_value)
            report_mismatch($sformatf("reply %0d entry_value %h, expected %h",
                                      checked, got.entry_value, want.entry_value));
        if (got.fill_count !== want.fill_count)
            report_mismatch($sformatf("reply %0d fill_count %0d, expected %0d",
                                      checked, got.fill_count, want.fill_count));
        if (got.last !== want.last)
            report_mismatch($sformatf("reply %0d last %b, expected %b",
                                      checked, got.last, want.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
                compare_reply(res);
            if (cmd_valid && cmd_ready)
                table_op_outcome(cmd);
            pending = awaited_replies.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives the unsorted array table engine with a directed opening and then
// phases of random requests (filling, back-pressure, draining, mixed), with
// random gaps on both channels; a separate checker predicts every reply
// ----------------------------------------------------------------------------
module testbench;

    localparam int TBL_DEPTH     = 16;
    localparam int CYCLE_LIMIT   = 400000;
    // long result-side stall that backs the engine up into the request side
    localparam int HOLD_CYCLES   = 300;
    // margin for the replies of the last request, longer than any one request
    localparam int SETTLE_CYCLES = 2 * TBL_DEPTH + 8;

    // codes the engine does not use; they must still give one plain reply
    localparam logic [2:0] FN_SPARE5 = 3'd5;
    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    uate_pkg::cmd_t cmd;
    logic res_valid;
    logic res_ready;
    uate_pkg::res_t res;

    int fails;
    int pending;
    int checked;
    int cycle_cnt;
    int sent;

    // idling switches for the request side and the result side
    bit src_idle_on;
    bit snk_idle_on;
    // one-shot request for the long result-side hold-off
    bit hold_req;

    // small value pool so that search, update and delete hit stored entries
    logic [31:0] key_pool [8];

    unsorted_array_table_engine #(
        .DEPTH(TBL_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    table_checker #(
        .DEPTH(TBL_DEPTH)
    ) CHECK (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .fails    (fails),
        .pending  (pending),
        .checked  (checked)
    );

    // clock, period of 2
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // watchdog: a hung handshake or a lost reply ends the run here
    initial cycle_cnt = 0;
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stall bursts, plus the long hold-off when asked
    initial
    begin
        res_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (snk_idle_on && $urandom_range(0, 3) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // offer one request and hold it until the engine takes it, then maybe
    // drop valid for a random burst
    task automatic send_request(input logic [2:0] f, input logic [31:0] k,
                                input logic [31:0] v);
        uate_pkg::cmd_t c;
        c.func      = f;
        c.key       = k;
        c.new_value = v;
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        sent++;
        if (src_idle_on && $urandom_range(0, 2) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // mostly pool values so lookups hit, sometimes a fully random pattern
    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // weighted choice of operation in percent; what is left goes to spare codes
    function automatic logic [2:0] pick_func(input int w_ins, input int w_dump,
                                             input int w_find, input int w_upd,
                                             input int w_del);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < w_ins)
            return uate_pkg::FN_INSERT;
        roll -= w_ins;
        if (roll < w_dump)
            return uate_pkg::FN_DUMP;
        roll -= w_dump;
        if (roll < w_find)
            return uate_pkg::FN_SEARCH;
        roll -= w_find;
        if (roll < w_upd)
            return uate_pkg::FN_UPDATE;
        roll -= w_upd;
        if (roll < w_del)
            return uate_pkg::FN_DELETE;
        case ($urandom_range(0, 2))
            0:       return FN_SPARE5;
            1:       return FN_SPARE6;
            default: return FN_SPARE7;
        endcase
    endfunction

    // one phase of random requests with a given operation mix
    task automatic run_mix(input int n, input int w_ins, input int w_dump,
                           input int w_find, input int w_upd, input int w_del);
        logic [2:0]  f;
        logic [31:0] nv;
        repeat (n)
        begin
            f  = pick_func(w_ins, w_dump, w_find, w_upd, w_del);
            nv = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 7)] : $urandom();
            send_request(f, pick_key(), nv);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cmd_valid   <= 1'b0;
        cmd         <= '0;
        sent        = 0;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        hold_req    = 1'b0;

        // pool holds both extremes, zero, all ones and a few random values
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 8; i++)
            key_pool[i] = $urandom();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: dump gives a single empty reply, lookups all miss
        send_request(uate_pkg::FN_DUMP,   32'h0000_0000, 32'h0000_0000);
        send_request(uate_pkg::FN_SEARCH, 32'h0000_0000, 32'h0000_0000);
        send_request(uate_pkg::FN_UPDATE, 32'h8000_0000, 32'h7fff_ffff);
        send_request(uate_pkg::FN_DELETE, 32'hffff_ffff, 32'h0000_0000);

        // extremes of the value range, with a duplicate of the maximum
        send_request(uate_pkg::FN_INSERT, 32'h8000_0000, 32'hffff_ffff);
        send_request(uate_pkg::FN_INSERT, 32'h7fff_ffff, 32'h0000_0000);
        send_request(uate_pkg::FN_INSERT, 32'h0000_0000, 32'h8000_0000);
        send_request(uate_pkg::FN_INSERT, 32'hffff_ffff, 32'h7fff_ffff);
        send_request(uate_pkg::FN_INSERT, 32'h7fff_ffff, 32'h0000_0000);

        // first match wins for search, also on a duplicate made by update; update miss leaves all alone
        send_request(uate_pkg::FN_SEARCH, 32'h7fff_ffff, 32'h0000_0000);
        send_request(uate_pkg::FN_UPDATE, 32'h0000_0000, 32'h8000_0000);
        send_request(uate_pkg::FN_UPDATE, 32'h1234_5678, 32'hffff_ffff);
        send_request(uate_pkg::FN_SEARCH, 32'h8000_0000, 32'h0000_0000);

        // deletes at the head shift the rest down, then delete of the last slot
        send_request(uate_pkg::FN_DELETE, 32'h8000_0000, 32'h0000_0000);
        send_request(uate_pkg::FN_DELETE, 32'h7fff_ffff, 32'h0000_0000);
        send_request(uate_pkg::FN_DELETE, 32'h7fff_ffff, 32'h0000_0000);
        // delete miss must not move anything
        send_request(uate_pkg::FN_DELETE, 32'h55aa_55aa, 32'h0000_0000);

        // unused codes: no state change, one plain reply
        send_request(FN_SPARE5, $urandom(), $urandom());
        send_request(FN_SPARE6, $urandom(), $urandom());
        send_request(FN_SPARE7, $urandom(), $urandom());

        send_request(uate_pkg::FN_UPDATE, 32'hffff_ffff, 32'h7fff_ffff);
        send_request(uate_pkg::FN_DUMP,   32'h0000_0000, 32'h0000_0000);

        // insert-heavy: fills the table and keeps knocking on a full one
        run_mix(40, 70, 5, 10, 10, 3);

        // long result-side hold while dumps of a full table keep coming
        hold_req = 1'b1;
        run_mix(12, 30, 50, 10, 5, 3);

        // delete-heavy: drains the table back down
        run_mix(40, 10, 10, 15, 10, 50);

        // balanced mix
        run_mix(60, 25, 10, 20, 20, 20);

        // last stretch with no idling on either side
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        run_mix(40, 25, 10, 20, 20, 20);
        cmd_valid <= 1'b0;

        // let every reply drain, with margin for the last request
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests issued, %0d replies checked", sent, checked);
        $display("ran empty and full table, first-match lookups, long dumps, result back-pressure");
        if (fails == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
